>>> design/sacl_pkg.sv
`default_nettype none
package sacl_pkg;

	localparam int MAX_SET_BITS = 6;
	localparam int WAYS         = 8;
	localparam int ADDR_W       = 64;
	localparam int MAX_OFF      = 16;
	localparam int SETS         = 1 << MAX_SET_BITS;
	localparam int SET_W        = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int WAY_W        = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int WCNT_W       = $clog2(WAYS + 1);
	localparam int LVL          = $clog2(WAYS);
	localparam int STAMP_W      = 32;
	localparam int CNT_W        = 32;

	// configuration register indexes
	localparam logic [1:0] CFG_SET_BITS = 2'd0;
	localparam logic [1:0] CFG_OFF_BITS = 2'd1;
	localparam logic [1:0] CFG_WAYS     = 2'd2;

	// access kinds
	localparam logic [1:0] MODE_FETCH  = 2'd0;
	localparam logic [1:0] MODE_MODIFY = 2'd1;
	localparam logic [1:0] MODE_LOAD   = 2'd2;
	localparam logic [1:0] MODE_STORE  = 2'd3;

	// outcomes
	localparam logic [1:0] OUT_HIT   = 2'd0;
	localparam logic [1:0] OUT_FILL  = 2'd1;
	localparam logic [1:0] OUT_EVICT = 2'd2;
	localparam logic [1:0] OUT_FETCH = 2'd3;

	typedef struct packed {
		logic                valid;
		logic [ADDR_W-1:0]   tag;
		logic [STAMP_W-1:0]  stamp;
	} line_t;

	typedef line_t [WAYS-1:0] row_t;

	typedef struct packed {
		logic accept;
		logic compare;
		logic update;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_full;
	} dp_stat_t;

endpackage
`default_nettype wire

>>> design/sacl_ctrl.sv
`default_nettype none
module sacl_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 out_ready,
	input  wire sacl_pkg::dp_stat_t   stat,
	output sacl_pkg::ctrl_cmd_t       cmd
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CMP  = 3'b010,
		ST_UPD  = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   upd_go;

	// result can land once the output register is empty or being drained
	assign upd_go = !stat.out_full || out_ready;

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		cmd.accept  = 1'b0;
		cmd.compare = 1'b0;
		cmd.update  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid) state_d = ST_CMP;
			end
			ST_CMP: begin
				cmd.compare = 1'b1;
				state_d     = ST_UPD;
			end
			ST_UPD: begin
				cmd.update = upd_go;
				if (upd_go) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

endmodule
`default_nettype wire

>>> design/sacl_dp.sv
`default_nettype none
module sacl_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire sacl_pkg::ctrl_cmd_t           cmd,
	output sacl_pkg::dp_stat_t                 stat,
	input  wire logic                          cfg_valid,
	input  wire logic [1:0]                    cfg_index,
	input  wire logic [4:0]                    cfg_data,
	input  wire logic [1:0]                    mode,
	input  wire logic [63:0]                   address,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [1:0]                         outcome,
	output logic                               extra_hit,
	output logic [sacl_pkg::CNT_W-1:0]         hit_count,
	output logic [sacl_pkg::CNT_W-1:0]         miss_count,
	output logic [sacl_pkg::CNT_W-1:0]         evict_count
);

	localparam int NODES = 1 << sacl_pkg::LVL;

	// configuration
	logic [2:0] sbits_q;
	logic [4:0] obits_q;
	logic [3:0] ways_q;

	logic [2:0]                      s_eff;
	logic [4:0]                      b_eff;
	logic [sacl_pkg::WCNT_W-1:0]     e_eff;
	logic [sacl_pkg::ADDR_W-1:0]     addr_in;
	logic [sacl_pkg::ADDR_W-1:0]     addr_sh;
	logic [sacl_pkg::SET_W-1:0]      set_idx;
	logic [sacl_pkg::ADDR_W-1:0]     tag_in;

	// set array
	sacl_pkg::row_t                  mem [sacl_pkg::SETS];
	logic [sacl_pkg::SETS-1:0]       row_ok_q;
	sacl_pkg::row_t                  rd_row_s1;
	logic                            row_ok_s1;
	logic [1:0]                      mode_s1;
	logic [sacl_pkg::SET_W-1:0]      set_s1;
	logic [sacl_pkg::ADDR_W-1:0]     tag_s1;
	logic [sacl_pkg::STAMP_W-1:0]    stamp_q;

	// compare stage
	logic [sacl_pkg::WAYS-1:0]       vv, hitv, emptv, cand;
	logic [sacl_pkg::STAMP_W-1:0]    age [sacl_pkg::WAYS];
	logic [sacl_pkg::WAY_W-1:0]      hit_way, empty_way;
	logic                            hit_s2, empty_s2;
	logic [sacl_pkg::WAY_W-1:0]      hit_way_s2, empty_way_s2;
	logic [sacl_pkg::WAYS-1:0]       vv_s2, cand_s2;
	logic [sacl_pkg::STAMP_W-1:0]    age_s2 [sacl_pkg::WAYS];

	// victim tree
	logic [sacl_pkg::STAMP_W-1:0]    t_age [sacl_pkg::LVL+1][NODES];
	logic                            t_ok  [sacl_pkg::LVL+1][NODES];
	logic [sacl_pkg::WAY_W-1:0]      t_idx [sacl_pkg::LVL+1][NODES];

	// update stage
	logic [sacl_pkg::WAY_W-1:0]      slot;
	sacl_pkg::row_t                  new_row;
	logic                            do_write;
	logic [1:0]                      outcome_d;
	logic                            is_mod;
	logic [sacl_pkg::CNT_W:0]        hit_sum, miss_sum, evict_sum;
	logic [sacl_pkg::CNT_W-1:0]      hits_q, misses_q, evicts_q;
	logic [sacl_pkg::CNT_W-1:0]      hits_d, misses_d, evicts_d;
	logic                            out_valid_q;
	logic [1:0]                      outcome_q;
	logic                            extra_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sbits_q <= '0;
			obits_q <= '0;
			ways_q  <= 4'd1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				sacl_pkg::CFG_SET_BITS: sbits_q <= cfg_data[2:0];
				sacl_pkg::CFG_OFF_BITS: obits_q <= cfg_data;
				sacl_pkg::CFG_WAYS:     ways_q  <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// effective geometry
	always_comb begin
		s_eff = (32'(sbits_q) > sacl_pkg::MAX_SET_BITS) ? 3'(sacl_pkg::MAX_SET_BITS) : sbits_q;
		b_eff = (32'(obits_q) > sacl_pkg::MAX_OFF) ? 5'(sacl_pkg::MAX_OFF) : obits_q;
		if (ways_q == 4'd0) e_eff = sacl_pkg::WCNT_W'(1);
		else if (32'(ways_q) > sacl_pkg::WAYS) e_eff = sacl_pkg::WCNT_W'(sacl_pkg::WAYS);
		else e_eff = sacl_pkg::WCNT_W'(ways_q);
	end

	assign addr_in = address[sacl_pkg::ADDR_W-1:0];
	assign addr_sh = addr_in >> b_eff;
	assign set_idx = addr_sh[sacl_pkg::SET_W-1:0] & ~({sacl_pkg::SET_W{1'b1}} << s_eff);
	assign tag_in  = addr_in >> (6'(b_eff) + 6'(s_eff));

	// set read on accept
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rd_row_s1 <= mem[set_idx];
			mode_s1   <= mode;
			set_s1    <= set_idx;
			tag_s1    <= tag_in;
		end
		if (do_write) mem[set_s1] <= new_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_ok_q  <= '0;
			row_ok_s1 <= 1'b0;
			stamp_q   <= '0;
		end else begin
			if (cmd.accept) begin
				row_ok_s1 <= row_ok_q[set_idx];
				stamp_q   <= stamp_q + 1'b1;
			end
			if (do_write) row_ok_q[set_s1] <= 1'b1;
		end
	end

	// parallel tag compare and ages
	always_comb begin
		hit_way   = '0;
		empty_way = '0;
		for (int w = 0; w < sacl_pkg::WAYS; w++) begin
			vv[w]    = row_ok_s1 & rd_row_s1[w].valid;
			cand[w]  = vv[w] && (e_eff > sacl_pkg::WCNT_W'(w));
			hitv[w]  = cand[w] && (rd_row_s1[w].tag == tag_s1);
			emptv[w] = !vv[w] && (e_eff > sacl_pkg::WCNT_W'(w));
			age[w]   = stamp_q - rd_row_s1[w].stamp;
		end
		for (int w = sacl_pkg::WAYS - 1; w >= 0; w--) begin
			if (hitv[w]) hit_way = sacl_pkg::WAY_W'(w);
			if (emptv[w]) empty_way = sacl_pkg::WAY_W'(w);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.compare) begin
			hit_s2       <= |hitv;
			empty_s2     <= |emptv;
			hit_way_s2   <= hit_way;
			empty_way_s2 <= empty_way;
			vv_s2        <= vv;
			cand_s2      <= cand;
			for (int w = 0; w < sacl_pkg::WAYS; w++) age_s2[w] <= age[w];
		end
	end

	// oldest valid way, lower way wins ties
	always_comb begin
		for (int i = 0; i < NODES; i++) begin
			t_age[0][i] = (i < sacl_pkg::WAYS) ? age_s2[i % sacl_pkg::WAYS] : '0;
			t_ok[0][i]  = (i < sacl_pkg::WAYS) ? cand_s2[i % sacl_pkg::WAYS] : 1'b0;
			t_idx[0][i] = sacl_pkg::WAY_W'(i);
		end
		for (int l = 1; l <= sacl_pkg::LVL; l++) begin
			for (int i = 0; i < NODES; i++) begin
				t_age[l][i] = t_age[l-1][i];
				t_ok[l][i]  = t_ok[l-1][i];
				t_idx[l][i] = t_idx[l-1][i];
				if (i < (NODES >> l)) begin
					if (t_ok[l-1][2*i+1] &&
					    (!t_ok[l-1][2*i] || t_age[l-1][2*i+1] > t_age[l-1][2*i])) begin
						t_age[l][i] = t_age[l-1][2*i+1];
						t_ok[l][i]  = 1'b1;
						t_idx[l][i] = t_idx[l-1][2*i+1];
					end else begin
						t_age[l][i] = t_age[l-1][2*i];
						t_ok[l][i]  = t_ok[l-1][2*i];
						t_idx[l][i] = t_idx[l-1][2*i];
					end
				end
			end
		end
	end

	// write-back and counters
	always_comb begin
		is_mod = (mode_s1 == sacl_pkg::MODE_MODIFY);
		if (mode_s1 == sacl_pkg::MODE_FETCH) outcome_d = sacl_pkg::OUT_FETCH;
		else if (hit_s2) outcome_d = sacl_pkg::OUT_HIT;
		else if (empty_s2) outcome_d = sacl_pkg::OUT_FILL;
		else outcome_d = sacl_pkg::OUT_EVICT;

		if (hit_s2) slot = hit_way_s2;
		else if (empty_s2) slot = empty_way_s2;
		else slot = t_idx[sacl_pkg::LVL][0];

		new_row = rd_row_s1;
		for (int w = 0; w < sacl_pkg::WAYS; w++) new_row[w].valid = vv_s2[w];
		new_row[slot].valid = 1'b1;
		new_row[slot].stamp = stamp_q;
		if (!hit_s2) new_row[slot].tag = tag_s1;

		do_write = cmd.update && (mode_s1 != sacl_pkg::MODE_FETCH);

		hit_sum   = {1'b0, hits_q} + (sacl_pkg::CNT_W+1)'(outcome_d == sacl_pkg::OUT_HIT)
		            + (sacl_pkg::CNT_W+1)'(is_mod);
		miss_sum  = {1'b0, misses_q} + (sacl_pkg::CNT_W+1)'(outcome_d == sacl_pkg::OUT_FILL
		            || outcome_d == sacl_pkg::OUT_EVICT);
		evict_sum = {1'b0, evicts_q} + (sacl_pkg::CNT_W+1)'(outcome_d == sacl_pkg::OUT_EVICT);
		hits_d    = hit_sum[sacl_pkg::CNT_W] ? '1 : hit_sum[sacl_pkg::CNT_W-1:0];
		misses_d  = miss_sum[sacl_pkg::CNT_W] ? '1 : miss_sum[sacl_pkg::CNT_W-1:0];
		evicts_d  = evict_sum[sacl_pkg::CNT_W] ? '1 : evict_sum[sacl_pkg::CNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hits_q      <= '0;
			misses_q    <= '0;
			evicts_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.update) begin
				hits_q      <= hits_d;
				misses_q    <= misses_d;
				evicts_q    <= evicts_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			outcome_q <= outcome_d;
			extra_q   <= is_mod;
		end
	end

	assign stat.out_full = out_valid_q;
	assign out_valid     = out_valid_q;
	assign outcome       = outcome_q;
	assign extra_hit     = extra_q;
	assign hit_count     = hits_q;
	assign miss_count    = misses_q;
	assign evict_count   = evicts_q;

endmodule
`default_nettype wire

>>> design/set_assoc_lru_cache_sim_unit.sv
// An access is taken only while idle: set read on accept, tag compare with
// ages, then LRU pick, write-back on the single set array and result register
// load, which waits while out stalls; the next access follows only after that.
// Reset: asynchronous; per-set valid flags clear at once, so no clearing pass.
// Counters, access stamp and geometry registers return to their defaults.
`default_nettype none
module set_assoc_lru_cache_sim_unit (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [4:0]   cfg_data,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic [1:0]   mode,
	input  wire logic [63:0]  address,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic [1:0]        outcome,
	output logic              extra_hit,
	output logic [31:0]       hit_count,
	output logic [31:0]       miss_count,
	output logic [31:0]       evict_count
);

	sacl_pkg::ctrl_cmd_t cmd;
	sacl_pkg::dp_stat_t  stat;

	assign cfg_ready = 1'b1;

	sacl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	sacl_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mode        (mode),
		.address     (address),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.outcome     (outcome),
		.extra_hit   (extra_hit),
		.hit_count   (hit_count),
		.miss_count  (miss_count),
		.evict_count (evict_count)
	);

endmodule
`default_nettype wire

>>> sim/tb_set_assoc_lru_cache_sim_unit.sv
`default_nettype none
module tb_set_assoc_lru_cache_sim_unit;
	import sacl_pkg::*;

	localparam logic [1:0] CFG_SPARE = 2'd3;
	localparam int LINE_COUNT   = SETS * WAYS;
	localparam int QUIET_CYCLES = 5;
	localparam int STALL_LIMIT  = 2000;
	localparam int CALM_TAIL    = 150;
	localparam int PHASES       = 12;
	localparam int PHASE_ITEMS  = 125;

	typedef enum logic {OP_ACCESS, OP_WRITE} op_kind_e;

	typedef struct packed {
		op_kind_e    kind;
		logic [1:0]  mode;
		logic [63:0] address;
		logic [1:0]  reg_idx;
		logic [4:0]  reg_val;
	} op_t;

	typedef struct packed {
		logic [1:0]  outcome;
		logic        extra_hit;
		logic [31:0] hits;
		logic [31:0] misses;
		logic [31:0] evicts;
	} stats_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = CFG_SET_BITS;
	logic [4:0]  cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  mode = MODE_FETCH;
	logic [63:0] address = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  outcome;
	logic        extra_hit;
	logic [31:0] hit_count;
	logic [31:0] miss_count;
	logic [31:0] evict_count;

	set_assoc_lru_cache_sim_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.address    (address),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.outcome    (outcome),
		.extra_hit  (extra_hit),
		.hit_count  (hit_count),
		.miss_count (miss_count),
		.evict_count(evict_count)
	);

	// cache shadow
	logic        line_ok   [LINE_COUNT];
	logic [63:0] line_tg   [LINE_COUNT];
	logic [31:0] line_seen [LINE_COUNT];
	logic [31:0] stamp_now;
	logic [31:0] hits_m;
	logic [31:0] misses_m;
	logic [31:0] evicts_m;
	logic [2:0]  set_bits_r;
	logic [4:0]  off_bits_r;
	logic [3:0]  ways_r;

	op_t    pending_ops[$];
	stats_t lookup_results[$];
	int     op_total;
	int     ops_done = 0;
	int     mismatch_count = 0;
	int     idle_pct = 0;
	int     gap_left = 0;
	int     stall_left = 0;
	int     quiet_cnt = 0;
	int     still_cycles = 0;

	initial forever #1 clk = ~clk;

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	function automatic void apply_write(input logic [1:0] idx, input logic [4:0] val);
		case (idx)
			CFG_SET_BITS: set_bits_r = val[2:0];
			CFG_OFF_BITS: off_bits_r = val;
			CFG_WAYS:     ways_r = val[3:0];
			default: ;
		endcase
	endfunction

	function automatic void predict_lookup(input logic [1:0] m, input logic [63:0] a);
		int unsigned s, b, e, base, slot;
		int          hit_way, empty_way, victim;
		logic [31:0] age, oldest;
		logic [63:0] tg;
		stats_t      r;
		s = (set_bits_r > MAX_SET_BITS) ? MAX_SET_BITS : set_bits_r;
		b = (off_bits_r > MAX_OFF) ? MAX_OFF : off_bits_r;
		e = (ways_r == 0) ? 1 : ((ways_r > WAYS) ? WAYS : ways_r);
		stamp_now = stamp_now + 32'd1;
		r.outcome = OUT_FETCH;
		r.extra_hit = 1'b0;
		if (m != MODE_FETCH) begin
			base = ((a >> b) & ((64'd1 << s) - 64'd1)) * WAYS;
			tg = a >> (b + s);
			hit_way = -1;
			empty_way = -1;
			victim = -1;
			oldest = '0;
			slot = base;
			for (int w = 0; w < e && hit_way < 0; w++) begin
				if (line_ok[base + w]) begin
					age = stamp_now - line_seen[base + w];
					if (line_tg[base + w] == tg)
						hit_way = w;
					else if (victim < 0 || age > oldest) begin
						victim = w;
						oldest = age;
					end
				end else if (empty_way < 0) begin
					empty_way = w;
				end
			end
			if (hit_way >= 0) begin
				r.outcome = OUT_HIT;
				slot = base + hit_way;
				hits_m = sat_inc(hits_m);
			end else begin
				if (empty_way >= 0) begin
					r.outcome = OUT_FILL;
					slot = base + empty_way;
				end else begin
					r.outcome = OUT_EVICT;
					slot = base + victim;
					evicts_m = sat_inc(evicts_m);
				end
				misses_m = sat_inc(misses_m);
				line_ok[slot] = 1'b1;
				line_tg[slot] = tg;
			end
			line_seen[slot] = stamp_now;
			if (m == MODE_MODIFY) begin
				r.extra_hit = 1'b1;
				hits_m = sat_inc(hits_m);
			end
		end
		r.hits = hits_m;
		r.misses = misses_m;
		r.evicts = evicts_m;
		lookup_results.push_back(r);
	endfunction

	task automatic push_access(input logic [1:0] m, input logic [63:0] a);
		op_t o;
		o = '0;
		o.kind = OP_ACCESS;
		o.mode = m;
		o.address = a;
		pending_ops.push_back(o);
	endtask

	task automatic push_write(input logic [1:0] idx, input logic [4:0] val);
		op_t o;
		o = '0;
		o.kind = OP_WRITE;
		o.reg_idx = idx;
		o.reg_val = val;
		pending_ops.push_back(o);
	endtask

	task automatic check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
			mismatch_count++;
		end
	endtask

	// driver: accesses and register writes, in queue order
	always @(posedge clk) begin : driver
		op_t  o;
		logic in_hold, cfg_hold, in_next, cfg_next;
		if (!arst_n) begin
			in_valid <= 1'b0;
			cfg_valid <= 1'b0;
		end else begin
			in_hold = in_valid && !in_ready;
			cfg_hold = cfg_valid && !cfg_ready;
			if (in_valid && in_ready) begin
				predict_lookup(mode, address);
				ops_done++;
			end
			if (cfg_valid && cfg_ready) begin
				apply_write(cfg_index, cfg_data);
				ops_done++;
				case ($urandom_range(0, 2))
					0: idle_pct = 0;
					1: idle_pct = 8;
					default: idle_pct = 25;
				endcase
			end
			if (pending_ops.size() < CALM_TAIL)
				idle_pct = 0;
			// writes go only to an idle block
			if (lookup_results.size() == 0 && !in_valid && !out_valid)
				quiet_cnt++;
			else
				quiet_cnt = 0;
			if (!in_hold && !cfg_hold) begin
				in_next = 1'b0;
				cfg_next = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_ops.size() != 0) begin
					o = pending_ops[0];
					if (o.kind == OP_ACCESS) begin
						void'(pending_ops.pop_front());
						in_next = 1'b1;
						mode <= o.mode;
						address <= o.address;
					end else if (quiet_cnt >= QUIET_CYCLES) begin
						void'(pending_ops.pop_front());
						cfg_next = 1'b1;
						cfg_index <= o.reg_idx;
						cfg_data <= o.reg_val;
					end
					if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct)
						gap_left = $urandom_range(1, 18);
				end
				in_valid <= in_next;
				cfg_valid <= cfg_next;
			end
		end
	end

	// monitor: result checks and receiver stalls
	always @(posedge clk) begin : monitor
		stats_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (lookup_results.size() == 0) begin
					$display("%0t: unexpected result: outcome %0d hits %0d", $time,
						outcome, hit_count);
					mismatch_count++;
				end else begin
					want = lookup_results.pop_front();
					check_field("outcome", want.outcome, outcome);
					check_field("extra_hit", want.extra_hit, extra_hit);
					check_field("hit_count", want.hits, hit_count);
					check_field("miss_count", want.misses, miss_count);
					check_field("evict_count", want.evicts, evict_count);
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
				stall_left = $urandom_range(0, 17);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((in_valid && in_ready) || (cfg_valid && cfg_ready) || (out_valid && out_ready)) begin
				still_cycles = 0;
			end else begin
				still_cycles++;
				if (still_cycles >= STALL_LIMIT) begin
					$display("Testbench completed WITH ERRORS");
					$finish;
				end
			end
		end
	end

	initial begin : stimulus
		logic [2:0]  sb;
		logic [4:0]  ob;
		logic [3:0]  wy;
		logic [31:0] junk;
		logic [63:0] rnd, addr;
		logic [63:0] set_pick [3];
		logic [63:0] tag_pick [12];
		int unsigned es, eb, ee, n_sets, n_tags;

		for (int i = 0; i < LINE_COUNT; i++) begin
			line_ok[i] = 1'b0;
			line_tg[i] = '0;
			line_seen[i] = '0;
		end
		stamp_now = '0;
		hits_m = '0;
		misses_m = '0;
		evicts_m = '0;
		set_bits_r = '0;
		off_bits_r = '0;
		ways_r = 4'd1;

		// reset geometry: one set, one way, no offset
		push_access(MODE_FETCH, 64'd0);
		push_access(MODE_LOAD, 64'd0);
		push_access(MODE_LOAD, 64'd0);
		push_access(MODE_STORE, '1);
		push_access(MODE_MODIFY, '1);
		push_access(MODE_MODIFY, 64'd1);
		push_access(MODE_FETCH, '1);

		// every register above its range
		push_write(CFG_SET_BITS, 5'h1F);
		push_write(CFG_OFF_BITS, 5'h1F);
		push_write(CFG_WAYS, 5'h1F);
		push_access(MODE_LOAD, 64'd0);
		push_access(MODE_LOAD, 64'hFFFF);
		push_access(MODE_LOAD, 64'd1 << 16);
		for (int t = 1; t <= 8; t++)
			push_access(MODE_STORE, 64'(t) << 22);
		push_access(MODE_LOAD, 64'd0);
		push_access(MODE_MODIFY, 64'h8000_0000_0000_0000);

		// set bits, offset bits and ways zero; old lines outside the new geometry stay put
		push_write(CFG_SET_BITS, 5'd0);
		push_write(CFG_OFF_BITS, 5'd0);
		push_write(CFG_WAYS, 5'd0);
		push_access(MODE_LOAD, 64'hAAAA_AAAA_AAAA_AAAA);
		push_access(MODE_STORE, 64'h5555_5555_5555_5555);
		push_access(MODE_MODIFY, 64'hAAAA_AAAA_AAAA_AAAA);
		push_write(CFG_SPARE, 5'h15);

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin sb = 3'd6; ob = 5'd16; wy = 4'd8; end
				1: begin sb = 3'd0; ob = 5'd0; wy = 4'd1; end
				2: begin sb = 3'd7; ob = 5'd31; wy = 4'd15; end
				3: begin sb = $urandom_range(0, 7); ob = $urandom_range(0, 31); wy = 4'd0; end
				default: begin
					sb = $urandom_range(0, 7);
					ob = $urandom_range(0, 31);
					wy = $urandom_range(0, 15);
				end
			endcase
			junk = $urandom();
			push_write(CFG_SET_BITS, {junk[1:0], sb});
			push_write(CFG_OFF_BITS, ob);
			push_write(CFG_WAYS, {junk[2], wy});
			es = (sb > MAX_SET_BITS) ? MAX_SET_BITS : sb;
			eb = (ob > MAX_OFF) ? MAX_OFF : ob;
			ee = (wy == 0) ? 1 : ((wy > WAYS) ? WAYS : wy);

			// small working set so hits and LRU evictions are common
			n_sets = $urandom_range(1, 3);
			n_tags = ee + $urandom_range(0, 3);
			for (int i = 0; i < 3; i++)
				set_pick[i] = $urandom_range(0, (1 << es) - 1);
			for (int i = 0; i < 12; i++)
				tag_pick[i] = {$urandom(), $urandom()};
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				rnd = {$urandom(), $urandom()};
				if ($urandom_range(0, 4) == 0)
					addr = rnd;
				else
					addr = (tag_pick[$urandom_range(0, n_tags - 1)] << (eb + es))
						| (set_pick[$urandom_range(0, n_sets - 1)] << eb)
						| (rnd & ((64'd1 << eb) - 64'd1));
				push_access(2'($urandom_range(0, 3)), addr);
			end
		end
		op_total = pending_ops.size();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		while (ops_done != op_total) @(posedge clk);
		while (lookup_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
`default_nettype wire
